// ===== rtl/core/rpq_pkg.sv =====
package rpq_pkg;

  // Default geometry of the ring
  localparam int SLOT_COUNT_DEFAULT  = 4;
  localparam int MAX_PAYLOAD_DEFAULT = 126;

  // Field widths fixed by the item formats
  localparam int BYTE_W   = 8;
  localparam int LIMIT_W  = 7;
  localparam int STATUS_W = 3;
  localparam int PLEN_W   = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd126;
  localparam logic [BYTE_W-1:0]  RSSI_TOP    = 8'hff;

  // Actions
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_STORED   = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_COMPLETE = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DROPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_READ     = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_TOO_LONG = 3'd6;

  typedef logic [LIMIT_W-1:0] limit_t;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] payload_byte;
    logic              byte_is_final;
    logic [BYTE_W-1:0] rssi_code;
  } item_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [BYTE_W-1:0]        read_byte;
    logic                     read_final;
    logic [PLEN_W-1:0]        packet_length;
    logic signed [BYTE_W-1:0] rssi_dbm;
    logic                     packets_pending;
  } item_out_t;

  // dBm from a raw RSSI code: -((255 - raw) >> 1)
  function automatic logic signed [BYTE_W-1:0] rssi_to_dbm(input logic [BYTE_W-1:0] raw);
    logic [BYTE_W-1:0] half;
    half = (RSSI_TOP - raw) >> 1;
    return BYTE_W'(-half);
  endfunction

endpackage

// ===== rtl/core/rpq_chan_if.sv =====
interface rpq_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/rpq_payload_mem.sv =====
module rpq_payload_mem #(
  parameter int DEPTH  = rpq_pkg::SLOT_COUNT_DEFAULT * rpq_pkg::MAX_PAYLOAD_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [rpq_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [rpq_pkg::BYTE_W-1:0] rd_data
);

  logic [rpq_pkg::BYTE_W-1:0] mem [DEPTH];

  // Write one byte per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/rx_packet_ring_queue.sv =====
// Receive packet ring queue.
// Channels: req (sink) carries one item per access: a pushed payload byte
// with its final flag and RSSI code, or a read request. rsp (source) returns
// exactly one result item per request, in order. cfg (sink) writes the read
// length limit; write it only while no request is in flight.
// Result path: a push, a read on an empty ring and a discard of a too-long
// head packet register their result straight from the accepted item. A
// read that returns a byte passes the payload memory's registered read port
// and the fetch state before its result is registered.
// Throughput: pushes one item per cycle unless req.ready drops; a byte read
// keeps req.ready low while it fetches, so no new request is taken meanwhile.
// Reset (rst, synchronous): ring empty, head and tail at slot zero, limit
// set to 126. The payload memory is not cleared; only committed bytes are
// ever read.
// Stalls: the result register is backed by one skid entry, so one more item
// is taken while a result waits; req.ready drops when the skid entry fills.
module rx_packet_ring_queue #(
  parameter int SLOT_COUNT  = rpq_pkg::SLOT_COUNT_DEFAULT,
  parameter int MAX_PAYLOAD = rpq_pkg::MAX_PAYLOAD_DEFAULT
) (
  input logic clk,
  input logic rst,
  rpq_chan_if.sink   req,
  rpq_chan_if.source rsp,
  rpq_chan_if.sink   cfg
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int CMP_W  = (LEN_W > rpq_pkg::LIMIT_W) ? LEN_W : rpq_pkg::LIMIT_W;
  localparam int DEPTH  = SLOT_COUNT * MAX_PAYLOAD;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [LEN_W-1:0]  MAX_LEN     = LEN_W'(MAX_PAYLOAD);
  localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [ADDR_W-1:0] SLOT_STRIDE = ADDR_W'(MAX_PAYLOAD);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_FETCH = 1'b1;

  // Control and ring state
  logic                  state, state_next;
  logic [SLOT_W-1:0]     head, head_next;
  logic [SLOT_W-1:0]     tail, tail_next;
  logic                  ring_empty, ring_empty_next;
  logic [LEN_W-1:0]      wr_off, wr_off_next;
  logic [LEN_W-1:0]      rd_off, rd_off_next;
  logic                  dropping, dropping_next;
  rpq_pkg::limit_t       limit;

  // Per-slot descriptors
  logic [LEN_W-1:0]           lengths  [SLOT_COUNT];
  logic [rpq_pkg::BYTE_W-1:0] rssi_tab [SLOT_COUNT];

  // Result path
  rpq_pkg::item_out_t out_r, skid_r, fetch_r, res;
  logic               out_valid, skid_valid;
  logic               res_now, enq;

  rpq_pkg::item_in_t  item;
  logic               accept;
  logic               commit;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [rpq_pkg::BYTE_W-1:0] mem_rdata;

  logic [LEN_W-1:0]   head_len;
  logic [LEN_W-1:0]   wr_inc, rd_inc;
  logic [SLOT_W-1:0]  head_adv, tail_adv;

  assign item     = req.data;
  assign req.ready = (state == S_IDLE) && !skid_valid;
  assign accept   = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign head_len = lengths[head];
  assign wr_inc   = wr_off + 1'b1;
  assign rd_inc   = rd_off + 1'b1;
  assign head_adv = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign tail_adv = (tail == LAST_SLOT) ? '0 : tail + 1'b1;

  assign mem_waddr = ADDR_W'(tail) * SLOT_STRIDE + ADDR_W'(wr_off);
  assign mem_raddr = ADDR_W'(head) * SLOT_STRIDE + ADDR_W'(rd_off);

  // Decide the effect of the accepted item
  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    ring_empty_next = ring_empty;
    wr_off_next     = wr_off;
    rd_off_next     = rd_off;
    dropping_next   = dropping;
    commit          = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    res_now         = 1'b0;
    res             = '0;

    if (state == S_FETCH) begin
      // Memory data is back: complete the byte read
      res           = fetch_r;
      res.read_byte = mem_rdata;
      state_next    = S_IDLE;
    end else if (accept) begin
      if (item.action == rpq_pkg::ACT_PUSH) begin
        res_now = 1'b1;
        if (dropping ||
            (wr_off == '0 && !ring_empty && head == tail)) begin
          // Drop the whole packet that started on a full ring
          res.status    = rpq_pkg::STAT_DROPPED;
          dropping_next = !item.byte_is_final;
        end else begin
          if (wr_off < MAX_LEN) begin
            mem_we      = 1'b1;
            wr_off_next = wr_inc;
            res.status  = rpq_pkg::STAT_STORED;
          end else begin
            res.status  = rpq_pkg::STAT_OVERFLOW;
          end
          res.packet_length = rpq_pkg::PLEN_W'(wr_off_next);
          if (item.byte_is_final) begin
            commit          = 1'b1;
            tail_next       = tail_adv;
            ring_empty_next = 1'b0;
            wr_off_next     = '0;
            res.status      = rpq_pkg::STAT_COMPLETE;
          end
        end
      end else begin
        if (ring_empty) begin
          res_now    = 1'b1;
          res.status = rpq_pkg::STAT_EMPTY;
        end else begin
          res.packet_length = rpq_pkg::PLEN_W'(head_len);
          if (rd_off == '0 && CMP_W'(head_len) > CMP_W'(limit)) begin
            // Discard a head packet over the limit
            res_now         = 1'b1;
            res.status      = rpq_pkg::STAT_TOO_LONG;
            head_next       = head_adv;
            rd_off_next     = '0;
            ring_empty_next = (head_adv == tail);
          end else begin
            // Start the payload read, finish next cycle
            mem_re       = 1'b1;
            state_next   = S_FETCH;
            res.status   = rpq_pkg::STAT_READ;
            res.rssi_dbm = rpq_pkg::rssi_to_dbm(rssi_tab[head]);
            rd_off_next  = rd_inc;
            if (rd_inc >= head_len) begin
              res.read_final  = 1'b1;
              head_next       = head_adv;
              rd_off_next     = '0;
              ring_empty_next = (head_adv == tail);
            end
          end
        end
      end
      res.packets_pending = !ring_empty_next;
    end

    enq = res_now || (state == S_FETCH);
  end

  // Advance ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      ring_empty <= 1'b1;
      wr_off     <= '0;
      rd_off     <= '0;
      dropping   <= 1'b0;
      limit      <= rpq_pkg::LIMIT_RESET;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      ring_empty <= ring_empty_next;
      wr_off     <= wr_off_next;
      rd_off     <= rd_off_next;
      dropping   <= dropping_next;
      if (cfg.valid && cfg.ready) begin
        limit <= cfg.data;
      end
    end
  end

  // Commit slot descriptors and hold the pending byte-read result
  always_ff @(posedge clk) begin
    if (commit) begin
      lengths[tail]  <= wr_off_next == '0 ? (wr_off < MAX_LEN ? wr_inc : wr_off) : wr_off_next;
      rssi_tab[tail] <= item.rssi_code;
    end
    if (mem_re) begin
      fetch_r <= res;
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= enq;
      end
    end else if (enq) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || rsp.ready) begin
      if (skid_valid) begin
        out_r <= skid_r;
      end else if (enq) begin
        out_r <= res;
      end
    end else if (enq) begin
      skid_r <= res;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_r;

  rpq_payload_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_payload_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (item.payload_byte),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule
